// ===== hw/rtl/spi_master_shift_engine_defines.svh =====
// Assertion macros for the SPI master shift engine checker.
// Uses the checker's aclk and aresetn ports; no other dependencies.
`ifndef SPI_MASTER_SHIFT_ENGINE_DEFINES_SVH
`define SPI_MASTER_SHIFT_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle, outside reset
`define SME_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the following cycle, outside reset
`define SME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the following cycle, also across reset
`define SME_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/spi_mse_pkg.sv =====
// Shared types, codes and constants for the SPI master shift engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package spi_mse_pkg;

    // Default shift register width
    localparam int WORD_BITS_DEF = 16;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_BITS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAUD_DIV    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLK_POL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLK_PHASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOPBACK    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TALK_EN     = 3'd5;

    // Reset values of the configuration registers
    localparam logic [4:0] CHAR_BITS_RST = 5'd16;
    localparam logic [6:0] BAUD_DIV_RST  = 7'd0;

    // Smallest effective baud divider
    localparam logic [6:0] BAUD_DIV_MIN = 7'd3;

    // Request opcodes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_WRITE_TX  = 3'd1;
    localparam logic [2:0] OP_READ_RX   = 3'd2;
    localparam logic [2:0] OP_STATUS    = 3'd3;
    localparam logic [2:0] OP_CLR_OVR   = 3'd4;

    // Request payload
    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] write_data;
        logic        serial_in;
    } req_t;

    // Result payload
    typedef struct packed {
        logic [15:0] read_data;
        logic        serial_clock;
        logic        serial_out;
        logic        serial_out_enable;
        logic        ready_flag;
        logic        overrun_flag;
        logic        busy_res;
    } rsp_t;

    // Decoded configuration handed from the register file to the engine
    typedef struct packed {
        logic [4:0] char_bits;
        logic [6:0] period_last;
        logic [6:0] half;
        logic       clock_polarity;
        logic       clock_phase;
        logic       loopback;
        logic       talk_enable;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spi_mse_cfg.sv =====
// Configuration register file of the SPI master shift engine.
// Depends on spi_mse_pkg for indexes, reset values and cfg_t.
`default_nettype none

module spi_mse_cfg (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [spi_mse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [spi_mse_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output spi_mse_pkg::cfg_t                       cfg
);
    import spi_mse_pkg::*;

    logic [4:0] char_bits_reg;
    logic [6:0] baud_div_reg;
    logic       clk_pol_reg;
    logic       clk_phase_reg;
    logic       loopback_reg;
    logic       talk_en_reg;
    logic [6:0] period_last;
    logic [7:0] period;

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_bits_reg <= CHAR_BITS_RST;
            baud_div_reg  <= BAUD_DIV_RST;
            clk_pol_reg   <= 1'b0;
            clk_phase_reg <= 1'b0;
            loopback_reg  <= 1'b0;
            talk_en_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CHAR_BITS: char_bits_reg <= cfg_wdata[4:0];
                CFG_BAUD_DIV:  baud_div_reg  <= cfg_wdata[6:0];
                CFG_CLK_POL:   clk_pol_reg   <= cfg_wdata[0];
                CFG_CLK_PHASE: clk_phase_reg <= cfg_wdata[0];
                CFG_LOOPBACK:  loopback_reg  <= cfg_wdata[0];
                CFG_TALK_EN:   talk_en_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Clamp the divider and derive the half-period point
    always_comb begin
        period_last = (baud_div_reg < BAUD_DIV_MIN) ? BAUD_DIV_MIN : baud_div_reg;
        period      = {1'b0, period_last} + 8'd1;
    end

    assign cfg.char_bits      = char_bits_reg;
    assign cfg.period_last    = period_last;
    assign cfg.half           = period[7:1];
    assign cfg.clock_polarity = clk_pol_reg;
    assign cfg.clock_phase    = clk_phase_reg;
    assign cfg.loopback       = loopback_reg;
    assign cfg.talk_enable    = talk_en_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/spi_mse_engine.sv =====
// Shift engine state and per-request update of the SPI master.
// Depends on spi_mse_pkg for opcodes, req_t, rsp_t and cfg_t.
`default_nettype none

module spi_mse_engine #(
    parameter int WORD_BITS = spi_mse_pkg::WORD_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire spi_mse_pkg::req_t req,
    input  wire spi_mse_pkg::cfg_t cfg,
    output spi_mse_pkg::rsp_t     rsp_next
);
    import spi_mse_pkg::*;

    localparam int BL_W = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] shift_reg,   shift_next;
    logic [WORD_BITS-1:0] rx_reg,      rx_next;
    logic [WORD_BITS-1:0] held_reg,    held_next;
    logic [BL_W-1:0]      bits_reg,    bits_next;
    logic [6:0]           phase_reg,   phase_next;
    logic                 active_reg,  active_next;
    logic                 ready_reg,   ready_next;
    logic                 ovr_reg,     ovr_next;
    logic                 hvalid_reg,  hvalid_next;
    logic                 sample_reg,  sample_next;

    logic [WORD_BITS-1:0] wdata_word;
    logic [WORD_BITS-1:0] shifted;
    logic [BL_W-1:0]      char_len;
    logic [BL_W-1:0]      bits_dec;
    logic [5:0]           cb_ext;
    logic [15:0]          rdata;
    logic                 serial_bit;
    logic                 clk_act;

    // Fit the 16-bit transmit word to the shift register width
    assign wdata_word = WORD_BITS'({16'd0, req.write_data});

    // Effective character length, latched when a transfer starts
    always_comb begin
        cb_ext = {1'b0, cfg.char_bits};
        if (cb_ext == 6'd0 || cb_ext > 6'(WORD_BITS)) begin
            char_len = BL_W'(WORD_BITS);
        end else begin
            char_len = BL_W'(cb_ext);
        end
    end

    // Advance the transfer or decode the bus access
    always_comb begin
        shift_next  = shift_reg;
        rx_next     = rx_reg;
        held_next   = held_reg;
        bits_next   = bits_reg;
        phase_next  = phase_reg;
        active_next = active_reg;
        ready_next  = ready_reg;
        ovr_next    = ovr_reg;
        hvalid_next = hvalid_reg;
        sample_next = sample_reg;
        rdata       = 16'd0;
        serial_bit  = cfg.loopback ? shift_reg[WORD_BITS-1] : req.serial_in;
        shifted     = '0;
        bits_dec    = '0;

        unique case (req.opcode)
            OP_TICK: begin
                if (active_reg) begin
                    if (phase_reg == cfg.half) begin
                        sample_next = serial_bit;
                    end
                    if (phase_reg >= cfg.period_last) begin
                        phase_next = 7'd0;
                        shifted    = {shift_reg[WORD_BITS-2:0], sample_next};
                        shift_next = shifted;
                        bits_dec   = (bits_reg != '0) ? bits_reg - 1'b1 : bits_reg;
                        bits_next  = bits_dec;
                        if (bits_dec == '0) begin
                            rx_next     = shifted;
                            ovr_next    = ovr_reg | ready_reg;
                            ready_next  = 1'b1;
                            active_next = 1'b0;
                            if (hvalid_reg) begin
                                hvalid_next = 1'b0;
                                shift_next  = held_reg;
                                bits_next   = char_len;
                                active_next = 1'b1;
                            end
                        end
                    end else begin
                        phase_next = phase_reg + 7'd1;
                    end
                end
            end
            OP_WRITE_TX: begin
                if (active_reg) begin
                    held_next   = wdata_word;
                    hvalid_next = 1'b1;
                end else begin
                    shift_next  = wdata_word;
                    bits_next   = char_len;
                    phase_next  = 7'd0;
                    active_next = 1'b1;
                end
            end
            OP_READ_RX: begin
                rdata      = 16'({16'd0, rx_reg});
                ready_next = 1'b0;
            end
            OP_CLR_OVR: begin
                ovr_next = 1'b0;
            end
            default: ;
        endcase
    end

    // Clock is active after the half point, or before it with delayed phase
    always_comb begin
        if (cfg.clock_phase) begin
            clk_act = phase_next < cfg.half;
        end else begin
            clk_act = phase_next >= cfg.half;
        end
    end

    assign rsp_next.read_data         = rdata;
    assign rsp_next.serial_clock      = cfg.clock_polarity ^ (active_next & clk_act);
    assign rsp_next.serial_out        = cfg.talk_enable & shift_next[WORD_BITS-1];
    assign rsp_next.serial_out_enable = cfg.talk_enable;
    assign rsp_next.ready_flag        = ready_next;
    assign rsp_next.overrun_flag      = ovr_next;
    assign rsp_next.busy_res          = active_next;

    // Hold state until a request is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg  <= '0;
            rx_reg     <= '0;
            held_reg   <= '0;
            bits_reg   <= '0;
            phase_reg  <= 7'd0;
            active_reg <= 1'b0;
            ready_reg  <= 1'b0;
            ovr_reg    <= 1'b0;
            hvalid_reg <= 1'b0;
            sample_reg <= 1'b0;
        end else if (step) begin
            shift_reg  <= shift_next;
            rx_reg     <= rx_next;
            held_reg   <= held_next;
            bits_reg   <= bits_next;
            phase_reg  <= phase_next;
            active_reg <= active_next;
            ready_reg  <= ready_next;
            ovr_reg    <= ovr_next;
            hvalid_reg <= hvalid_next;
            sample_reg <= sample_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spi_master_shift_engine.sv =====
// SPI master shift engine, top level: request register, engine, result register.
// A request passes from the request register through the engine into the result register.
// Throughput: one request per cycle, unless a stalled result register holds the request back.
// Reset (aresetn low, synchronous) empties both registers, clears the engine
// state and loads the configuration reset values.
`default_nettype none

module spi_master_shift_engine #(
    parameter int WORD_BITS = spi_mse_pkg::WORD_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire spi_mse_pkg::req_t                  s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output spi_mse_pkg::rsp_t                       m_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [spi_mse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [spi_mse_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import spi_mse_pkg::*;

    req_t req_reg;
    logic req_valid_reg;
    rsp_t rsp_reg;
    logic rsp_valid_reg;
    rsp_t rsp_next;
    cfg_t cfg;
    logic step;

    // Process the held request when the result register is free or draining
    assign step    = req_valid_reg & (~rsp_valid_reg | m_ready);
    assign s_ready = ~req_valid_reg | step;
    assign m_valid = rsp_valid_reg;
    assign m_data  = rsp_reg;

    spi_mse_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    spi_mse_engine #(
        .WORD_BITS (WORD_BITS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .req      (req_reg),
        .cfg      (cfg),
        .rsp_next (rsp_next)
    );

    // Capture an incoming request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready & s_valid) begin
            req_reg <= s_data;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsp_valid_reg <= 1'b0;
        end else if (step) begin
            rsp_valid_reg <= 1'b1;
        end else if (m_ready) begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spi_mse_checker.sv =====
// Port-level checker for the SPI master shift engine, bound to the top level.
// Depends on spi_mse_pkg and the assertion macros in the defines header.
`default_nettype none
`include "spi_master_shift_engine_defines.svh"

module spi_mse_props (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire spi_mse_pkg::req_t                  s_data,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire spi_mse_pkg::rsp_t                  m_data,
    input wire logic                               cfg_wr_en,
    input wire logic [spi_mse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic [spi_mse_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import spi_mse_pkg::*;

    // A stalled result keeps its contents
    `SME_ASSERT_NEXT(a_rsp_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // With the result register empty a request is always taken
    `SME_ASSERT_NOW(a_accept_when_empty, !m_valid, s_ready, "request refused with empty output")

    // Disabled output never drives a one
    `SME_ASSERT_NOW(a_out_disabled, m_valid && !m_data.serial_out_enable, !m_data.serial_out, "serial data high while disabled")

    // Reset leaves no result pending
    `SME_ASSERT_ALWAYS_NEXT(a_reset_empty, !aresetn, !m_valid, "result valid right after reset")

endmodule

bind spi_master_shift_engine spi_mse_props u_spi_mse_checker (.*);

`default_nettype wire

// ===== verif/spi_mse_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the SPI master shift engine: watches the request, result and
// register-write ports, predicts each result and compares it field by field.
// Depends on spi_mse_pkg for payload types, opcodes and register indexes.
module spi_mse_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  spi_mse_pkg::req_t                  s_data,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  spi_mse_pkg::rsp_t                  m_data,
    input  logic                               cfg_wr_en,
    input  logic [spi_mse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spi_mse_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                                 mismatches,
    output int                                 pending
);
    import spi_mse_pkg::*;

    localparam int WB           = WORD_BITS_DEF;
    localparam int REPORT_LIMIT = 10;

    // Shadow copies of the configuration registers
    logic [4:0] char_bits_r;
    logic [6:0] baud_div_r;
    logic       pol_r;
    logic       pha_r;
    logic       loop_r;
    logic       talk_r;

    // Shadow engine state
    logic [WB-1:0] shift_q;
    logic [WB-1:0] rx_buf;
    logic [WB-1:0] held_q;
    logic [4:0]    bits_to_go;
    logic [6:0]    tick_cnt;
    logic          xfer_busy;
    logic          rdy_flag;
    logic          ovr_flag;
    logic          held_full;
    logic          data_latch;

    // Predicted line and flag states, oldest first
    rsp_t line_state_q[$];

    // Ticks per bit, with the divider floored at its minimum
    function automatic int bit_period();
        int d;
        d = (baud_div_r < BAUD_DIV_MIN) ? int'(BAUD_DIV_MIN) : int'(baud_div_r);
        return d + 1;
    endfunction

    // Load a character; an out-of-range length means a full word
    function automatic void load_char(logic [WB-1:0] w);
        logic [4:0] n;
        n = char_bits_r;
        if (n == 0 || n > WB) n = 5'(WB);
        shift_q    = w;
        bits_to_go = n;
        tick_cnt   = '0;
        xfer_busy  = 1'b1;
    endfunction

    // Apply one request to the shadow engine and return the levels it leaves
    function automatic rsp_t spi_engine_step(req_t rq);
        rsp_t res;
        int   per;
        int   half;
        logic din;
        res = '0;
        case (rq.opcode)
            OP_TICK: begin
                if (xfer_busy) begin
                    per  = bit_period();
                    half = per / 2;
                    din  = loop_r ? shift_q[WB-1] : rq.serial_in;
                    // latch input at mid-bit, shift at the end of the bit
                    if (int'(tick_cnt) == half) data_latch = din;
                    if (int'(tick_cnt) + 1 >= per) begin
                        tick_cnt = '0;
                        shift_q  = {shift_q[WB-2:0], data_latch};
                        if (bits_to_go != 0) bits_to_go = bits_to_go - 1'b1;
                        if (bits_to_go == 0) begin
                            rx_buf    = shift_q;
                            ovr_flag  = ovr_flag | rdy_flag;
                            rdy_flag  = 1'b1;
                            xfer_busy = 1'b0;
                            if (held_full) begin
                                held_full = 1'b0;
                                load_char(held_q);
                            end
                        end
                    end else begin
                        tick_cnt = tick_cnt + 1'b1;
                    end
                end
            end
            OP_WRITE_TX: begin
                // queue behind a running transfer, else start at once
                if (xfer_busy) begin
                    held_q    = rq.write_data;
                    held_full = 1'b1;
                end else begin
                    load_char(rq.write_data);
                end
            end
            OP_READ_RX: begin
                res.read_data = rx_buf;
                rdy_flag      = 1'b0;
            end
            OP_CLR_OVR: begin
                ovr_flag = 1'b0;
            end
            default: begin
            end
        endcase

        // Clock idles at the polarity level and toggles per half bit
        res.serial_clock = pol_r;
        if (xfer_busy) begin
            half = bit_period() / 2;
            res.serial_clock = pol_r ^ (pha_r ? (int'(tick_cnt) < half)
                                              : (int'(tick_cnt) >= half));
        end
        res.serial_out        = talk_r & shift_q[WB-1];
        res.serial_out_enable = talk_r;
        res.ready_flag        = rdy_flag;
        res.overrun_flag      = ovr_flag;
        res.busy_res          = xfer_busy;
        return res;
    endfunction

    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            char_bits_r = CHAR_BITS_RST;
            baud_div_r  = BAUD_DIV_RST;
            pol_r       = 1'b0;
            pha_r       = 1'b0;
            loop_r      = 1'b0;
            talk_r      = 1'b0;
            shift_q     = '0;
            rx_buf      = '0;
            held_q      = '0;
            bits_to_go  = '0;
            tick_cnt    = '0;
            xfer_busy   = 1'b0;
            rdy_flag    = 1'b0;
            ovr_flag    = 1'b0;
            held_full   = 1'b0;
            data_latch  = 1'b0;
            mismatches  = 0;
            line_state_q.delete();
        end else begin
            // Track register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_CHAR_BITS: char_bits_r = cfg_wdata[4:0];
                    CFG_BAUD_DIV:  baud_div_r  = cfg_wdata[6:0];
                    CFG_CLK_POL:   pol_r       = cfg_wdata[0];
                    CFG_CLK_PHASE: pha_r       = cfg_wdata[0];
                    CFG_LOOPBACK:  loop_r      = cfg_wdata[0];
                    CFG_TALK_EN:   talk_r      = cfg_wdata[0];
                    default: begin
                    end
                endcase
            end

            // Compare the accepted result against the oldest prediction
            if (m_valid && m_ready) begin
                if (line_state_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result with none outstanding: rd=%h flags=%b",
                                 $realtime, m_data.read_data, m_data[5:0]);
                end else begin
                    want = line_state_q.pop_front();
                    if (want.read_data !== m_data.read_data
                            || want.serial_clock !== m_data.serial_clock
                            || want.serial_out !== m_data.serial_out
                            || want.serial_out_enable !== m_data.serial_out_enable
                            || want.ready_flag !== m_data.ready_flag
                            || want.overrun_flag !== m_data.overrun_flag
                            || want.busy_res !== m_data.busy_res) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t: result mismatch: exp rd=%h sck=%b so=%b oe=%b ",
                                      "rdy=%b ovr=%b busy=%b / got rd=%h sck=%b so=%b ",
                                      "oe=%b rdy=%b ovr=%b busy=%b"},
                                     $realtime,
                                     want.read_data, want.serial_clock, want.serial_out,
                                     want.serial_out_enable, want.ready_flag,
                                     want.overrun_flag, want.busy_res,
                                     m_data.read_data, m_data.serial_clock,
                                     m_data.serial_out, m_data.serial_out_enable,
                                     m_data.ready_flag, m_data.overrun_flag,
                                     m_data.busy_res);
                    end
                end
            end

            // Predict the accepted request
            if (s_valid && s_ready) line_state_q.push_back(spi_engine_step(s_data));
        end
        pending = line_state_q.size();
    end

endmodule

// ===== verif/tb_spi_master_shift_engine.sv =====
`timescale 1ns / 100ps
// Testbench top for the SPI master shift engine: clock, reset, register
// set-up, request stimulus, result back-pressure and the verdict.
// Depends on spi_mse_pkg, the engine RTL and spi_mse_checker.
module tb_spi_master_shift_engine;
    import spi_mse_pkg::*;

    localparam int RESET_CYCLES     = 10;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int HOLD_OFF_PHASE   = 2;
    localparam int DRAIN_CYCLES     = 4;
    localparam int NUM_PHASES       = 8;
    localparam int PHASE_ITEMS      = 100;
    localparam int SLOW_PHASE_ITEMS = 220;

    // Opcodes the engine ignores
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // Receiver stall modes
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    req_t                  s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    rsp_t                  m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    mismatches;
    int                    pending;
    int                    quiet_cycles = 0;
    bit                    hold_off_req = 1'b0;

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    spi_master_shift_engine DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    spi_mse_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Abort when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[spi_master_shift_engine] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result back-pressure: windows of a randomly chosen stall mode, plus one long hold-off
    initial begin
        int          win_cnt;
        int          rx_mode;
        logic [15:0] pat;
        win_cnt = 0;
        rx_mode = RX_ALWAYS;
        pat     = '1;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                if (win_cnt == 0) begin
                    rx_mode = $urandom_range(RX_ALWAYS, RX_PATTERN);
                    pat     = 16'($urandom) | 16'h0101;
                    win_cnt = $urandom_range(16, 96);
                end
                win_cnt--;
                case (rx_mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= ($urandom_range(0, 99) < 60);
                    default:   m_ready <= pat[win_cnt % 16];
                endcase
            end
        end
    end

    function automatic req_t make_req(logic [2:0] op, logic [15:0] wd, logic si);
        req_t r;
        r.opcode     = op;
        r.write_data = wd;
        r.serial_in  = si;
        return r;
    endfunction

    // Mostly ticks so transfers complete; the rest are bus accesses
    function automatic req_t random_req();
        req_t r;
        int   pick;
        pick         = $urandom_range(0, 99);
        r.write_data = 16'($urandom_range(0, 65535));
        r.serial_in  = 1'($urandom_range(0, 1));
        if (pick < 72)      r.opcode = OP_TICK;
        else if (pick < 80) r.opcode = OP_WRITE_TX;
        else if (pick < 87) r.opcode = OP_READ_RX;
        else if (pick < 91) r.opcode = OP_STATUS;
        else if (pick < 95) r.opcode = OP_CLR_OVR;
        else                r.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        return r;
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_req(input req_t r);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drain outstanding results, then write every register
    task automatic apply_link_setup(input logic [4:0] cb, input logic [6:0] bd,
                                    input logic pol, input logic pha,
                                    input logic lb, input logic te);
        logic [CFG_IDX_W-1:0]  idx[6];
        logic [CFG_DATA_W-1:0] vals[6];
        int                    i;
        idx[0] = CFG_CHAR_BITS;  vals[0] = 7'(cb);
        idx[1] = CFG_BAUD_DIV;   vals[1] = bd;
        idx[2] = CFG_CLK_POL;    vals[2] = 7'(pol);
        idx[3] = CFG_CLK_PHASE;  vals[3] = 7'(pha);
        idx[4] = CFG_LOOPBACK;   vals[4] = 7'(lb);
        idx[5] = CFG_TALK_EN;    vals[5] = 7'(te);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        for (i = 0; i < 6; i++) begin
            if (i > 0) @(negedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int   phase;
        int   n;
        int   counted;
        int   quota;
        int   burst_left;
        int   gap;
        bit   hold_used;
        req_t rq;
        hold_used = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: two-bit characters, a held word, overrun and its clear
        apply_link_setup(5'd2, 7'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        send_req(make_req(OP_CLR_OVR, 16'h0000, 1'b0));
        send_req(make_req(OP_READ_RX, 16'hFFFF, 1'b1));
        send_req(make_req(OP_SPARE_FIRST, 16'h5555, 1'b0));
        send_req(make_req(OP_SPARE_LAST, 16'hAAAA, 1'b1));
        send_req(make_req(OP_WRITE_TX, 16'hFFFF, 1'b0));
        // second write lands in the holding buffer
        send_req(make_req(OP_WRITE_TX, 16'h8000, 1'b1));
        for (n = 0; n < 16; n++) send_req(make_req(OP_TICK, 16'h0000, n[1]));
        send_req(make_req(OP_READ_RX, 16'h0000, 1'b0));
        send_req(make_req(OP_STATUS, 16'hFFFF, 1'b1));
        send_req(make_req(OP_CLR_OVR, 16'h0000, 1'b0));

        // Random phases, each under its own register setting
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: apply_link_setup(5'd16, 7'd0,   1'b0, 1'b0, 1'b0, 1'b1);
                1: apply_link_setup(5'd1,  7'd127, 1'b1, 1'b1, 1'b1, 1'b1);
                2: apply_link_setup(5'd0,  7'd3,   1'b0, 1'b1, 1'b0, 1'b1);
                3: apply_link_setup(5'd31, 7'd2,   1'b1, 1'b0, 1'b1, 1'b0);
                4: apply_link_setup(5'd17, 7'd1,   1'b1, 1'b1, 1'b0, 1'b1);
                default: apply_link_setup(5'($urandom_range(0, 31)),
                                          ($urandom_range(0, 3) == 0)
                                              ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 6)),
                                          1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1)));
            endcase
            // the slow-divider phase needs room for a whole character
            quota      = (phase == 1) ? SLOW_PHASE_ITEMS : PHASE_ITEMS;
            counted    = 0;
            burst_left = $urandom_range(1, 40);
            while (counted < quota) begin
                rq = random_req();
                send_req(rq);
                if (rq.opcode < OP_SPARE_FIRST) counted++;
                // stall the receiver while requests keep coming
                if (phase == HOLD_OFF_PHASE && !hold_used) begin
                    hold_off_req = 1'b1;
                    hold_used    = 1'b1;
                end
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap > 0) begin
                        @(negedge aclk);
                        s_valid <= 1'b0;
                        repeat (gap - 1) @(negedge aclk);
                    end
                end
            end
        end

        // Wait for the last results, then settle
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[spi_master_shift_engine] OK");
        end else begin
            $display("[spi_master_shift_engine] ERROR");
        end
        $finish;
    end

endmodule
